// ----- sv/ric_pkg.sv -----
// Shared types and constants for the RV64 instruction classifier.
`timescale 1ns / 1ps

package ric_pkg;

	localparam logic [6:0] OPC_LOAD     = 7'h03;
	localparam logic [6:0] OPC_FENCE    = 7'h0f;
	localparam logic [6:0] OPC_OPIMM    = 7'h13;
	localparam logic [6:0] OPC_AUIPC    = 7'h17;
	localparam logic [6:0] OPC_OPIMM32  = 7'h1b;
	localparam logic [6:0] OPC_STORE    = 7'h23;
	localparam logic [6:0] OPC_AMO      = 7'h2f;
	localparam logic [6:0] OPC_RTYPE    = 7'h33;
	localparam logic [6:0] OPC_LUI      = 7'h37;
	localparam logic [6:0] OPC_RTYPE32  = 7'h3b;
	localparam logic [6:0] OPC_BRANCH   = 7'h63;
	localparam logic [6:0] OPC_JALR     = 7'h67;
	localparam logic [6:0] OPC_JAL      = 7'h6f;
	localparam logic [6:0] OPC_SYSTEM   = 7'h73;

	localparam logic [11:0] CSR_WFI     = 12'h105;
	localparam logic [11:0] CSR_URET    = 12'h002;
	localparam logic [11:0] CSR_SRET    = 12'h102;
	localparam logic [11:0] CSR_HRET    = 12'h202;
	localparam logic [11:0] CSR_MRET    = 12'h302;
	localparam logic [24:0] EBREAK_HIGH = 25'h0002000;
	localparam logic [13:0] SYS_LOW14   = 14'h0073;
	localparam logic [6:0]  SFENCE_F7   = 7'h09;

	typedef enum logic [5:0] {
		K_UNKNOWN = 6'd0,  K_NOP     = 6'd1,  K_RGEN    = 6'd2,
		K_ADD     = 6'd3,  K_SUB     = 6'd4,  K_MUL     = 6'd5,  K_DIV     = 6'd6,
		K_MIN     = 6'd7,  K_SH2ADD  = 6'd8,  K_XNOR    = 6'd9,  K_XOR     = 6'd10,
		K_SLL     = 6'd11, K_MULH    = 6'd12, K_ROL     = 6'd13, K_SH1ADD  = 6'd14,
		K_SLT     = 6'd15, K_SLTU    = 6'd16, K_MULHU   = 6'd17, K_SRL     = 6'd18,
		K_DIVU    = 6'd19, K_MINU    = 6'd20, K_CZEROEQZ = 6'd21, K_SRA    = 6'd22,
		K_ROR     = 6'd23, K_OR      = 6'd24, K_REM     = 6'd25, K_MAX     = 6'd26,
		K_SH3ADD  = 6'd27, K_ORN     = 6'd28,
		K_LB      = 6'd29, K_LH      = 6'd30, K_LW      = 6'd31, K_LD      = 6'd32,
		K_LBU     = 6'd33, K_LHU     = 6'd34, K_LWU     = 6'd35,
		K_SB      = 6'd36, K_SH      = 6'd37, K_SW      = 6'd38, K_SD      = 6'd39,
		K_BEQ     = 6'd40, K_BNE     = 6'd41, K_BLT     = 6'd42, K_BGE     = 6'd43,
		K_BLTU    = 6'd44, K_BGEU    = 6'd45,
		K_LUI     = 6'd46, K_AUIPC   = 6'd47, K_ITYPE   = 6'd48, K_FENCE   = 6'd49,
		K_ATOMIC  = 6'd50, K_JR      = 6'd51, K_JALR    = 6'd52, K_J       = 6'd53,
		K_JAL     = 6'd54, K_SFENCE  = 6'd55, K_WFI     = 6'd56, K_SRET    = 6'd57,
		K_MRET    = 6'd58, K_EBREAK  = 6'd59, K_CSRRW   = 6'd60, K_CSRRSC  = 6'd61,
		K_CSRI    = 6'd62
	} kind_t;

	// predecoded fields and compares, built in front of stage 1
	typedef struct packed {
		logic [6:0] opc;
		logic [2:0] f3;
		logic [6:0] f7;
		logic       rd_zero;
		logic       hi_zero;    // bits 31:7 all zero
		logic       mid_zero;   // bits 19:7 all zero
		logic       low14_sys;
		logic       ebreak;
		logic       csr_wfi;
		logic       csr_uret;
		logic       csr_sret;
		logic       csr_hret;
		logic       csr_mret;
	} pre_t;

	typedef struct packed {
		kind_t kind;
		logic  fatal;
	} cls_t;

endpackage

// ----- sv/ric_classify.sv -----
// Class code and fatal decision from predecoded instruction fields.
`timescale 1ns / 1ps

module ric_classify import ric_pkg::*; (
	input  pre_t pre,
	output cls_t cls
);

	kind_t rkind;

	always_comb begin
		rkind = K_RGEN;
		case (pre.f3)
			3'd0: begin
				if (pre.f7 == 7'h00) rkind = K_ADD;
				else if (pre.f7 == 7'h01) rkind = K_MUL;
				else if (pre.f7 == 7'h20) rkind = K_SUB;
			end
			3'd1: begin
				if (pre.f7 == 7'h00) rkind = K_SLL;
				else if (pre.f7 == 7'h01) rkind = K_MULH;
				else if (pre.f7 == 7'h30) rkind = K_ROL;
			end
			3'd2: begin
				if (pre.f7 == 7'h00) rkind = K_SLT;
				else if (pre.f7 == 7'h10) rkind = K_SH1ADD;
			end
			3'd3: begin
				if (pre.f7 == 7'h00) rkind = K_SLTU;
				else if (pre.f7 == 7'h01) rkind = K_MULHU;
			end
			3'd4: begin
				if (pre.f7 == 7'h00) rkind = K_XOR;
				else if (pre.f7 == 7'h01) rkind = K_DIV;
				else if (pre.f7 == 7'h05) rkind = K_MIN;
				else if (pre.f7 == 7'h10) rkind = K_SH2ADD;
				else if (pre.f7 == 7'h20) rkind = K_XNOR;
			end
			3'd5: begin
				if (pre.f7 == 7'h00) rkind = K_SRL;
				else if (pre.f7 == 7'h01) rkind = K_DIVU;
				else if (pre.f7 == 7'h05) rkind = K_MINU;
				else if (pre.f7 == 7'h07) rkind = K_CZEROEQZ;
				else if (pre.f7 == 7'h20) rkind = K_SRA;
				else if (pre.f7 == 7'h30) rkind = K_ROR;
			end
			3'd6: begin
				if (pre.f7 == 7'h00) rkind = K_OR;
				else if (pre.f7 == 7'h01) rkind = K_REM;
				else if (pre.f7 == 7'h05) rkind = K_MAX;
				else if (pre.f7 == 7'h10) rkind = K_SH3ADD;
				else if (pre.f7 == 7'h20) rkind = K_ORN;
			end
			default: rkind = K_RGEN;
		endcase
	end

	always_comb begin
		cls.kind  = K_UNKNOWN;
		cls.fatal = 1'b0;
		case (pre.opc)
			OPC_LOAD: begin
				case (pre.f3)
					3'd0: cls.kind = K_LB;
					3'd1: cls.kind = K_LH;
					3'd2: cls.kind = K_LW;
					3'd3: cls.kind = K_LD;
					3'd4: cls.kind = K_LBU;
					3'd5: cls.kind = K_LHU;
					3'd6: cls.kind = K_LWU;
					default: cls.kind = K_UNKNOWN;
				endcase
			end
			OPC_FENCE:   cls.kind = K_FENCE;
			OPC_OPIMM:   cls.kind = (pre.f3 == 3'd0 && pre.rd_zero) ? K_NOP : K_ITYPE;
			OPC_AUIPC:   cls.kind = K_AUIPC;
			OPC_OPIMM32: cls.kind = K_ITYPE;
			OPC_STORE: begin
				case (pre.f3)
					3'd0: cls.kind = K_SB;
					3'd1: cls.kind = K_SH;
					3'd2: cls.kind = K_SW;
					3'd3: cls.kind = K_SD;
					default: cls.kind = K_UNKNOWN;
				endcase
			end
			OPC_AMO:     cls.kind = K_ATOMIC;
			OPC_LUI:     cls.kind = K_LUI;
			OPC_JALR:    cls.kind = pre.rd_zero ? K_JR : K_JALR;
			OPC_JAL:     cls.kind = pre.rd_zero ? K_J : K_JAL;
			OPC_RTYPE:   cls.kind = pre.rd_zero ? K_NOP : rkind;
			OPC_RTYPE32: cls.kind = pre.rd_zero ? K_NOP : K_RGEN;
			OPC_BRANCH: begin
				case (pre.f3)
					3'd0: cls.kind = K_BEQ;
					3'd1: cls.kind = K_BNE;
					3'd4: cls.kind = K_BLT;
					3'd5: cls.kind = K_BGE;
					3'd6: cls.kind = K_BLTU;
					3'd7: cls.kind = K_BGEU;
					default: cls.kind = K_UNKNOWN;
				endcase
			end
			OPC_SYSTEM: begin
				// priority order matters: ecall, sfence, xRET/wfi, ebreak, csr forms
				if (pre.hi_zero) cls.fatal = 1'b1;
				else if (pre.f7 == SFENCE_F7 && pre.low14_sys) cls.kind = K_SFENCE;
				else if (pre.mid_zero && pre.csr_wfi) cls.kind = K_WFI;
				else if (pre.mid_zero && pre.csr_uret) cls.fatal = 1'b1;
				else if (pre.mid_zero && pre.csr_sret) cls.kind = K_SRET;
				else if (pre.mid_zero && pre.csr_hret) cls.fatal = 1'b1;
				else if (pre.mid_zero && pre.csr_mret) cls.kind = K_MRET;
				else if (pre.ebreak) cls.kind = K_EBREAK;
				else if (pre.f3 == 3'd1) cls.kind = K_CSRRW;
				else if (pre.f3 inside {3'd2, 3'd3}) cls.kind = K_CSRRSC;
				else if (pre.f3 inside {[3'd5:3'd7]}) cls.kind = K_CSRI;
				else cls.fatal = 1'b1;
			end
			default: cls.kind = K_UNKNOWN;
		endcase
	end

endmodule

// ----- sv/riscv_instruction_classifier_core.sv -----
// Top level: three-stage pipelined RV64 instruction classifier.
//
//  channel      | handshake                          | fields
//  -------------+------------------------------------+----------------------------------
//  instruction  | instruction_valid / instruction_stall | instruction[31:0]
//  result       | result_valid / result_stall        | insn_kind .. mem_disp
//
// One word per cycle unless stalled; stages: predecode, classify, register-use rules.
// Each stage holds its own valid bit and loads when it is empty or the next one advances,
// so bubbles are squeezed out while the output is stalled.
// arst_n clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module riscv_instruction_classifier_core import ric_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               instruction_valid,
	output logic               instruction_stall,
	input  logic [31:0]        instruction,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [5:0]         insn_kind,
	output logic               fatal,
	output logic [4:0]         dest_reg,
	output logic               writes_dest,
	output logic [4:0]         src1_reg,
	output logic               reads_src1,
	output logic [4:0]         src2_reg,
	output logic               reads_src2,
	output logic               is_load,
	output logic               is_store,
	output logic signed [11:0] mem_disp
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        adv_s1, adv_s2, adv_s3;
	pre_t        pre_c, pre_s1;
	logic [31:0] word_s1, word_s2;
	cls_t        cls_c, cls_s2;

	assign adv_s3 = !valid_s3 || !result_stall;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign instruction_stall = !adv_s1;

	// stage 1: field compares
	always_comb begin
		pre_c.opc       = instruction[6:0];
		pre_c.f3        = instruction[14:12];
		pre_c.f7        = instruction[31:25];
		pre_c.rd_zero   = (instruction[11:7] == 5'd0);
		pre_c.hi_zero   = (instruction[31:7] == 25'd0);
		pre_c.mid_zero  = (instruction[19:7] == 13'd0);
		pre_c.low14_sys = (instruction[13:0] == SYS_LOW14);
		pre_c.ebreak    = (instruction[31:7] == EBREAK_HIGH);
		pre_c.csr_wfi   = (instruction[31:20] == CSR_WFI);
		pre_c.csr_uret  = (instruction[31:20] == CSR_URET);
		pre_c.csr_sret  = (instruction[31:20] == CSR_SRET);
		pre_c.csr_hret  = (instruction[31:20] == CSR_HRET);
		pre_c.csr_mret  = (instruction[31:20] == CSR_MRET);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= instruction_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && instruction_valid) begin
			pre_s1  <= pre_c;
			word_s1 <= instruction;
		end
	end

	// stage 2: class code
	ric_classify u_classify (
		.pre (pre_s1),
		.cls (cls_c)
	);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			cls_s2  <= cls_c;
			word_s2 <= word_s1;
		end
	end

	// stage 3: register-use rules and displacement
	logic       wd_c, r1_c, r2_c, ld_c, st_c;
	logic [11:0] disp_c;
	logic       rd_nz, rs1_nz;

	assign rd_nz  = (word_s2[11:7] != 5'd0);
	assign rs1_nz = (word_s2[19:15] != 5'd0);

	always_comb begin
		wd_c   = 1'b0;
		r1_c   = 1'b0;
		r2_c   = 1'b0;
		ld_c   = 1'b0;
		st_c   = 1'b0;
		disp_c = 12'd0;
		case (cls_s2.kind) inside
			[K_RGEN:K_ORN]: begin
				wd_c = 1'b1;
				r1_c = 1'b1;
				r2_c = 1'b1;
			end
			[K_LB:K_LWU]: begin
				wd_c   = 1'b1;
				r1_c   = 1'b1;
				ld_c   = 1'b1;
				disp_c = word_s2[31:20];
			end
			[K_SB:K_SD]: begin
				r1_c   = 1'b1;
				r2_c   = 1'b1;
				st_c   = 1'b1;
				disp_c = {word_s2[31:25], word_s2[11:7]};
			end
			[K_BEQ:K_BGEU]: begin
				r1_c = 1'b1;
				r2_c = 1'b1;
			end
			K_LUI, K_AUIPC, K_JAL: wd_c = 1'b1;
			K_ITYPE, K_JALR: begin
				wd_c = 1'b1;
				r1_c = 1'b1;
			end
			K_ATOMIC: begin
				wd_c = rd_nz;
				r1_c = 1'b1;
				r2_c = 1'b1;
				ld_c = 1'b1;
				st_c = 1'b1;
			end
			K_JR: r1_c = 1'b1;
			K_CSRRW: begin
				wd_c = rd_nz;
				r1_c = 1'b1;
			end
			K_CSRRSC: begin
				wd_c = rd_nz;
				r1_c = rs1_nz;
			end
			K_CSRI: wd_c = rd_nz;
			default: wd_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			insn_kind   <= cls_s2.kind;
			fatal       <= cls_s2.fatal;
			dest_reg    <= word_s2[11:7];
			writes_dest <= wd_c;
			src1_reg    <= word_s2[19:15];
			reads_src1  <= r1_c;
			src2_reg    <= word_s2[24:20];
			reads_src2  <= r2_c;
			is_load     <= ld_c;
			is_store    <= st_c;
			mem_disp    <= disp_c;
		end
	end

	assign result_valid = valid_s3;

endmodule

// ----- sv/ric_checker.sv -----
// Port-level checks for the classifier core, bound to the top level.
`timescale 1ns / 1ps

module ric_checker import ric_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               instruction_valid,
	input logic               instruction_stall,
	input logic [31:0]        instruction,
	input logic               result_valid,
	input logic               result_stall,
	input logic [5:0]         insn_kind,
	input logic               fatal,
	input logic [4:0]         dest_reg,
	input logic               writes_dest,
	input logic [4:0]         src1_reg,
	input logic               reads_src1,
	input logic [4:0]         src2_reg,
	input logic               reads_src2,
	input logic               is_load,
	input logic               is_store,
	input logic signed [11:0] mem_disp
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(insn_kind)
		&& $stable(mem_disp) && $stable(dest_reg))
		else $error("stalled result word changed");

	// refused system words carry no class and no flags
	a_fatal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fatal |-> insn_kind == K_UNKNOWN && !writes_dest && !reads_src1
		&& !reads_src2 && !is_load && !is_store && mem_disp == 12'sd0)
		else $error("fatal word with flags set");

	// only atomics are both load and store, and they have no displacement
	a_amo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_load && is_store |-> insn_kind == K_ATOMIC && mem_disp == 12'sd0)
		else $error("load and store on a non-atomic word");

	// a displacement only comes with a memory access
	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mem_disp != 12'sd0 |-> is_load || is_store)
		else $error("displacement without memory access");

endmodule

bind riscv_instruction_classifier_core ric_checker u_ric_checker (.*);
